FILE: rtl/isc_pkg.sv
package isc_pkg;

    // Fixed field widths of the request and result transactions.
    localparam int POS_W     = 7;
    localparam int OUT_VAL_W = 32;
    localparam int CNT_OUT_W = 7;

    // Number of cells whose candidate read values are merged into one
    // registered group word.
    localparam int GROUP_SIZE = 32;

    typedef enum logic [1:0] {
        REQ_INSERT    = 2'd0,
        REQ_REMOVE    = 2'd1,
        REQ_READ      = 2'd2,
        REQ_OVERWRITE = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Broadcast control to every cell of the chain. The flags are only set
    // for an accepted request that completes without error.
    typedef struct packed {
        logic             ins;
        logic             rem;
        logic             wr;
        logic [POS_W-1:0] pos;
    } t_cell_ctl;

endpackage

FILE: rtl/isc_cell.sv
module isc_cell #(
    parameter int unsigned INDEX       = 0,
    parameter int          VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  isc_pkg::t_cell_ctl     i_ctl,
    input  logic [VALUE_WIDTH-1:0] i_new_value,
    input  logic [VALUE_WIDTH-1:0] i_left,
    input  logic [VALUE_WIDTH-1:0] i_right,
    output logic [VALUE_WIDTH-1:0] o_value,
    output logic [VALUE_WIDTH-1:0] o_pick
);

    logic [VALUE_WIDTH-1:0] r_value;
    logic [VALUE_WIDTH-1:0] n_value;
    logic [31:0]            w_pos;
    logic                   w_hit;
    logic                   w_above;

    assign w_pos   = 32'(i_ctl.pos);
    assign w_hit   = (w_pos == INDEX);
    assign w_above = (INDEX > w_pos);

    // An insert pulls from the lower neighbor above the target, a remove
    // pulls from the upper neighbor at and above the target.
    always_comb begin
        n_value = r_value;
        priority if (i_ctl.ins && w_above) begin
            n_value = i_left;
        end else if ((i_ctl.ins || i_ctl.wr) && w_hit) begin
            n_value = i_new_value;
        end else if (i_ctl.rem && (w_hit || w_above)) begin
            n_value = i_right;
        end else begin
            n_value = r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_pick  = w_hit ? r_value : '0;

endmodule

FILE: rtl/indexed_sequence_store.sv
// A request transaction accepted by the block passes through the stage one register and then the
// output register, from which the receiver takes it when not stalling.
// Throughput: one request per cycle; the only stall comes from a held result on the output.
// The rate is set by the cell row, which shifts the whole tail at once, and a registered group merge.
// Reset (synchronous, active low) empties the store; entry contents are not cleared.
module indexed_sequence_store #(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [6:0]  i_position,
    input  logic [31:0] i_new_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_old_value,
    output logic [6:0]  o_entry_count,
    output logic [1:0]  o_status
);

    // Width of the fill count, and a width wide enough to compare the
    // count against a position.
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = (CW > isc_pkg::POS_W) ? CW : isc_pkg::POS_W;
    // Number of group words that the candidate read values are merged into.
    localparam int NG = (CAPACITY + isc_pkg::GROUP_SIZE - 1) / isc_pkg::GROUP_SIZE;

    // Control state.
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_s1_valid;
    logic          r_out_valid;

    // Stage one payload: the result fields that are already known at
    // acceptance, plus the merged candidate read values.
    isc_pkg::t_status                    r_s1_status;
    logic                                r_s1_take;
    logic [isc_pkg::CNT_OUT_W-1:0]       r_s1_count;
    logic [NG-1:0][VALUE_WIDTH-1:0]      r_grp;
    logic [NG-1:0][VALUE_WIDTH-1:0]      n_grp;

    // Output register.
    logic [isc_pkg::OUT_VAL_W-1:0]       r_old_value;
    logic [isc_pkg::CNT_OUT_W-1:0]       r_entry_count;
    isc_pkg::t_status                    r_status;

    logic                                w_accept;
    logic                                w_s1_ready;
    logic                                w_out_load;
    logic [KW-1:0]                       w_pos;
    logic [KW-1:0]                       w_cnt;
    logic                                w_full;
    logic                                w_ins;
    logic                                w_rem;
    logic                                w_wr;
    logic                                w_take;
    isc_pkg::t_status                    w_status;
    isc_pkg::t_cell_ctl                  w_ctl;
    logic [VALUE_WIDTH-1:0]              w_new_value;
    logic [VALUE_WIDTH-1:0]              w_sel;
    logic [CAPACITY-1:0][VALUE_WIDTH-1:0] w_q;
    logic [CAPACITY-1:0][VALUE_WIDTH-1:0] w_pick;

    // Handshake. Stage one moves into the output register whenever that
    // register is empty or being drained, and the input is taken whenever
    // stage one is empty or moving on.
    assign w_out_load = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign w_s1_ready = !r_s1_valid || w_out_load;
    assign o_in_stall = !w_s1_ready;
    assign w_accept   = i_in_valid && w_s1_ready;

    // Request decode and range checks against the current fill count.
    // Any error leaves the store and the count as they are.
    assign w_pos  = KW'(i_position);
    assign w_cnt  = KW'(r_count);
    assign w_full = (r_count == CW'(CAPACITY));

    always_comb begin
        w_ins    = 1'b0;
        w_rem    = 1'b0;
        w_wr     = 1'b0;
        w_take   = 1'b0;
        w_status = isc_pkg::ST_OK;
        n_count  = r_count;
        unique case (isc_pkg::t_req'(i_req_type))
            isc_pkg::REQ_INSERT: begin
                if (w_pos > w_cnt) begin
                    w_status = isc_pkg::ST_RANGE;
                end else if (w_full) begin
                    w_status = isc_pkg::ST_FULL;
                end else begin
                    w_ins   = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            isc_pkg::REQ_REMOVE: begin
                if (w_pos >= w_cnt) begin
                    w_status = isc_pkg::ST_RANGE;
                end else begin
                    w_rem   = 1'b1;
                    w_take  = 1'b1;
                    n_count = r_count - CW'(1);
                end
            end
            isc_pkg::REQ_READ: begin
                if (w_pos >= w_cnt) begin
                    w_status = isc_pkg::ST_RANGE;
                end else begin
                    w_take = 1'b1;
                end
            end
            isc_pkg::REQ_OVERWRITE: begin
                if (w_pos > w_cnt) begin
                    w_status = isc_pkg::ST_RANGE;
                end else if (w_pos == w_cnt) begin
                    // Overwriting one past the end appends the value.
                    if (w_full) begin
                        w_status = isc_pkg::ST_FULL;
                    end else begin
                        w_wr    = 1'b1;
                        n_count = r_count + CW'(1);
                    end
                end else begin
                    w_wr   = 1'b1;
                    w_take = 1'b1;
                end
            end
        endcase
    end

    // The control word is broadcast to every cell; the flags only fire for
    // an accepted transaction.
    assign w_ctl.ins   = w_accept && w_ins;
    assign w_ctl.rem   = w_accept && w_rem;
    assign w_ctl.wr    = w_accept && w_wr;
    assign w_ctl.pos   = i_position;
    assign w_new_value = VALUE_WIDTH'(i_new_value);

    // The row of cells. Each cell holds one entry and trades values with
    // its two neighbors, so an insert or remove shifts the whole tail
    // at once. The ends of the row see zero from outside.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VALUE_WIDTH-1:0] w_left;
        logic [VALUE_WIDTH-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_inner_l
            assign w_left = w_q[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_inner_r
            assign w_right = w_q[g+1];
        end

        isc_cell #(
            .INDEX       (g),
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_new_value (w_new_value),
            .i_left      (w_left),
            .i_right     (w_right),
            .o_value     (w_q[g]),
            .o_pick      (w_pick[g])
        );
    end

    // Only the cell at the requested position offers a nonzero candidate,
    // so the read value is a plain OR. It is merged per group of cells
    // here, before the cells update, and registered.
    always_comb begin
        n_grp = '0;
        for (int j = 0; j < NG; j++) begin
            for (int k = 0; k < isc_pkg::GROUP_SIZE; k++) begin
                if (j * isc_pkg::GROUP_SIZE + k < CAPACITY) begin
                    n_grp[j] = n_grp[j] | w_pick[j * isc_pkg::GROUP_SIZE + k];
                end
            end
        end
    end

    // Second merge over the registered group words.
    always_comb begin
        w_sel = '0;
        for (int j = 0; j < NG; j++) begin
            w_sel = w_sel | r_grp[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
            end
            if (w_s1_ready) begin
                r_s1_valid <= w_accept;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_status <= w_status;
            r_s1_take   <= w_take;
            r_s1_count  <= isc_pkg::CNT_OUT_W'(n_count);
            r_grp       <= n_grp;
        end
        if (w_out_load) begin
            r_old_value   <= r_s1_take ? isc_pkg::OUT_VAL_W'(w_sel) : '0;
            r_entry_count <= r_s1_count;
            r_status      <= r_s1_status;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_old_value   = r_old_value;
    assign o_entry_count = r_entry_count;
    assign o_status      = r_status;

endmodule

FILE: rtl/isc_checker.sv
module isc_checker #(
    parameter int CAPACITY = 64
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_old_value,
    input logic [6:0]  o_entry_count,
    input logic [1:0]  o_status
);

    // A result that is held back keeps its valid and its fields.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_old_value) && $stable(o_entry_count)
             && $stable(o_status)))
        else $error("held result transaction changed");

    // Requests are only held off while a finished result is backed up.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without output backpressure");

    // A failed request returns no value.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != isc_pkg::ST_OK)) |-> (o_old_value == 32'd0))
        else $error("error result carries a value");

    // A full error is only reported with the store at capacity.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == isc_pkg::ST_FULL)) |->
            (o_entry_count == 7'(CAPACITY)))
        else $error("full status with store below capacity");

endmodule

bind indexed_sequence_store isc_checker #(
    .CAPACITY (CAPACITY)
) u_isc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_old_value   (o_old_value),
    .o_entry_count (o_entry_count),
    .o_status      (o_status)
);

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

localparam int STORE_CAPACITY = 64;

// One result transaction as the store should produce it.
typedef struct packed {
    logic [31:0]      old_value;
    logic [6:0]       entry_count;
    isc_pkg::t_status status;
} t_store_result;

// Keeps a private copy of the sequence, works out the result of every accepted
// request and holds those results until the block delivers them.
class store_scoreboard;
    logic [31:0]   cells [STORE_CAPACITY];
    int unsigned   fill;
    t_store_result pending_results [$];
    int unsigned   errors;

    function new();
        fill   = 0;
        errors = 0;
    endfunction

    function void note_request(isc_pkg::t_req req, logic [6:0] pos, logic [31:0] val);
        t_store_result r;
        int unsigned   p;
        int unsigned   i;
        p             = pos;
        r.old_value   = '0;
        r.entry_count = '0;
        r.status      = isc_pkg::ST_OK;
        case (req)
            isc_pkg::REQ_INSERT: begin
                if (p > fill) begin
                    r.status = isc_pkg::ST_RANGE;
                end else if (fill >= STORE_CAPACITY) begin
                    r.status = isc_pkg::ST_FULL;
                end else begin
                    for (i = fill; i > p; i--) cells[i] = cells[i-1];
                    cells[p] = val;
                    fill++;
                end
            end
            isc_pkg::REQ_REMOVE: begin
                if (p >= fill) begin
                    r.status = isc_pkg::ST_RANGE;
                end else begin
                    r.old_value = cells[p];
                    for (i = p; i + 1 < fill; i++) cells[i] = cells[i+1];
                    fill--;
                end
            end
            isc_pkg::REQ_READ: begin
                if (p >= fill) begin
                    r.status = isc_pkg::ST_RANGE;
                end else begin
                    r.old_value = cells[p];
                end
            end
            default: begin
                if (p > fill) begin
                    r.status = isc_pkg::ST_RANGE;
                end else if (p == fill) begin
                    if (fill >= STORE_CAPACITY) begin
                        r.status = isc_pkg::ST_FULL;
                    end else begin
                        cells[p] = val;
                        fill++;
                    end
                end else begin
                    r.old_value = cells[p];
                    cells[p]    = val;
                end
            end
        endcase
        r.entry_count = 7'(fill);
        pending_results.push_back(r);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (errors < 100) begin
            $display("%0t ns: mismatch in %s: got %0h, want %0h", $time, what, got, want);
        end
        errors++;
    endtask

    task check_result(logic [31:0] old_value, logic [6:0] entry_count, logic [1:0] status);
        t_store_result r;
        if (pending_results.size() == 0) begin
            report_mismatch("result with no request pending", {25'd0, entry_count}, '0);
        end else begin
            r = pending_results.pop_front();
            if (old_value !== r.old_value) begin
                report_mismatch("old_value", old_value, r.old_value);
            end
            if (entry_count !== r.entry_count) begin
                report_mismatch("entry_count", {25'd0, entry_count}, {25'd0, r.entry_count});
            end
            if (status !== r.status) begin
                report_mismatch("status", {30'd0, status}, {30'd0, r.status});
            end
        end
    endtask
endclass

module tb_top;

    // Cycles without any accepted transaction before the run is declared hung.
    // The longest honest quiet stretch is the receiver hold-off below.
    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 150;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic [1:0]  i_req_type    = 2'd0;
    logic [6:0]  i_position    = 7'd0;
    logic [31:0] i_new_value   = 32'd0;
    logic        i_out_stall   = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [31:0] o_old_value;
    logic [6:0]  o_entry_count;
    logic [1:0]  o_status;

    store_scoreboard sb = new();

    // Idle percentages of the current phase, and a one-shot request for a long
    // receiver hold-off that the stall process picks up and counts down itself.
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_ask      = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    indexed_sequence_store #(
        .CAPACITY    (STORE_CAPACITY),
        .VALUE_WIDTH (32)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_position    (i_position),
        .i_new_value   (i_new_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_old_value   (o_old_value),
        .o_entry_count (o_entry_count),
        .o_status      (o_status)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Offers one request transaction and returns right after the edge that
    // accepted it. Random idle cycles are inserted first, so a gap can fall
    // anywhere in the block's pipeline. The request is handed to the
    // scoreboard at the accepting edge, so the next request is chosen from an
    // up-to-date entry count.
    task automatic send_request(input isc_pkg::t_req req, input logic [6:0] pos,
                                input logic [31:0] val);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_req_type  <= req;
        i_position  <= pos;
        i_new_value <= val;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(req, pos, val);
    endtask

    // Holds the sender back until every expected result has arrived.
    task automatic wait_for_drain();
        while (sb.pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Receiver side. A pending hold-off wins over the random stall pattern;
    // otherwise the stall is drawn afresh every cycle.
    always @(posedge i_clk) begin
        if (hold_ask != 0) begin
            hold_left = hold_ask;
            hold_ask  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Result monitor. Signals are read right at the edge, before any update
    // of that edge lands, so this sees what the block saw.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_old_value, o_entry_count, o_status);
        end
    end

    // Watchdog: ends the run if no transaction moves on either side for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial begin
        int            send_mix [4];
        int            stall_mix [4];
        int            ph;
        int            k;
        int            blk;
        int            mode;
        int            roll;
        isc_pkg::t_req req;
        logic [6:0]    pos;
        logic [31:0]   val;

        send_mix  = '{0, 60, 0, 35};
        stall_mix = '{0, 0, 60, 35};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, starting from the empty store. Every request type on
        // an empty store, an appending overwrite, inserts at the front, the end
        // and the middle, reads at the last entry and one past it, overwrites in
        // the middle, one past the end and two past it, the largest position the
        // field can carry, and removes at the front, the end and the middle.
        send_request(isc_pkg::REQ_READ,      7'd0,   32'h0000_0000);
        send_request(isc_pkg::REQ_REMOVE,    7'd0,   32'h0000_0000);
        send_request(isc_pkg::REQ_INSERT,    7'd1,   32'h1111_1111);
        send_request(isc_pkg::REQ_OVERWRITE, 7'd1,   32'h2222_2222);
        send_request(isc_pkg::REQ_OVERWRITE, 7'd0,   32'h1234_5678);
        send_request(isc_pkg::REQ_INSERT,    7'd0,   32'hFFFF_FFFF);
        send_request(isc_pkg::REQ_INSERT,    7'd2,   32'h0000_0000);
        send_request(isc_pkg::REQ_INSERT,    7'd1,   32'hA5A5_5A5A);
        send_request(isc_pkg::REQ_READ,      7'd4,   32'h0000_0000);
        send_request(isc_pkg::REQ_READ,      7'd3,   32'hFFFF_FFFF);
        send_request(isc_pkg::REQ_OVERWRITE, 7'd2,   32'h5A5A_A5A5);
        send_request(isc_pkg::REQ_OVERWRITE, 7'd4,   32'hDEAD_BEEF);
        send_request(isc_pkg::REQ_OVERWRITE, 7'd6,   32'h0BAD_F00D);
        send_request(isc_pkg::REQ_INSERT,    7'd127, 32'hFFFF_FFFF);
        send_request(isc_pkg::REQ_READ,      7'd127, 32'h0000_0000);
        send_request(isc_pkg::REQ_REMOVE,    7'd127, 32'h0000_0000);
        send_request(isc_pkg::REQ_OVERWRITE, 7'd127, 32'hFFFF_FFFF);
        send_request(isc_pkg::REQ_REMOVE,    7'd0,   32'h0000_0000);
        send_request(isc_pkg::REQ_REMOVE,    7'd3,   32'h0000_0000);
        send_request(isc_pkg::REQ_REMOVE,    7'd1,   32'h0000_0000);
        send_request(isc_pkg::REQ_READ,      7'd0,   32'h0000_0000);
        send_request(isc_pkg::REQ_INSERT,    7'd3,   32'h7777_7777);
        i_in_valid <= 1'b0;
        wait_for_drain();

        // Random part in four idling phases. Blocks of requests rotate through
        // growing (fills the store up to capacity, so full errors show up),
        // shrinking (drains it down to empty) and an even mix. Most positions
        // are legal for the current count; the rest are drawn over the whole
        // field as noise.
        blk = 0;
        for (ph = 0; ph < 4; ph++) begin
            send_idle_pct = send_mix[ph];
            stall_pct     = stall_mix[ph];
            // In the phases where the sender runs flat out, open with a
            // long hold-off so the block backs up and stalls its input while
            // requests keep coming.
            if (ph == 0 || ph == 2) begin
                hold_ask = HOLD_CYCLES;
            end
            for (k = 0; k < 440; k++) begin
                if (k % 88 == 0) begin
                    blk++;
                end
                mode = blk % 4;
                roll = $urandom_range(0, 99);
                if (mode == 0 || mode == 1) begin
                    req = (roll < 65) ? isc_pkg::REQ_INSERT :
                          (roll < 85) ? isc_pkg::REQ_OVERWRITE :
                          (roll < 95) ? isc_pkg::REQ_READ : isc_pkg::REQ_REMOVE;
                end else if (mode == 2) begin
                    req = (roll < 65) ? isc_pkg::REQ_REMOVE :
                          (roll < 80) ? isc_pkg::REQ_READ :
                          (roll < 95) ? isc_pkg::REQ_INSERT : isc_pkg::REQ_OVERWRITE;
                end else begin
                    req = isc_pkg::t_req'(roll % 4);
                end

                if ($urandom_range(0, 99) < 12) begin
                    pos = 7'($urandom_range(0, 127));
                end else if (req == isc_pkg::REQ_INSERT) begin
                    pos = 7'($urandom_range(0, sb.fill));
                end else if (req == isc_pkg::REQ_OVERWRITE) begin
                    // Lean on the appending case, which has its own full error.
                    pos = ($urandom_range(0, 99) < 40) ? 7'(sb.fill) :
                          7'($urandom_range(0, sb.fill));
                end else begin
                    pos = (sb.fill == 0) ? 7'd0 : 7'($urandom_range(0, sb.fill - 1));
                end

                case ($urandom_range(0, 9))
                    0:       val = 32'h0000_0000;
                    1:       val = 32'hFFFF_FFFF;
                    default: val = $urandom;
                endcase

                send_request(req, pos, val);
            end
            // Pause the sender until the block has delivered everything.
            i_in_valid <= 1'b0;
            wait_for_drain();
        end

        // Give a stray extra result a chance to show up before the verdict.
        repeat (10) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/isc_pkg.sv
rtl/isc_cell.sv
rtl/indexed_sequence_store.sv
rtl/isc_checker.sv
tb/tb_top.sv
